// ----- src/qsrp_pkg.sv -----
// ----------------------------------------------------------------------------
// qsrp_pkg: shared constants for the quadrature synthesiser register planner
// Register addresses, fixed values and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package qsrp_pkg;
  localparam logic [27:0] MIN_FREQ      = 28'd3500000;
  localparam logic [31:0] LOW_BAND_HIGH = 32'd6950000;
  localparam logic [20:0] FRAC_DENOM    = 21'd1048575;
  localparam logic [7:0]  ADDR_PLL_A    = 8'd26;
  localparam logic [7:0]  ADDR_MS0      = 8'd42;
  localparam logic [7:0]  ADDR_MS1      = 8'd50;
  localparam logic [7:0]  ADDR_PLL_RST  = 8'd177;
  localparam logic [7:0]  ADDR_CLK0_CTL = 8'd16;
  localparam logic [7:0]  ADDR_CLK1_CTL = 8'd17;
  localparam logic [7:0]  ADDR_CLK0_PH  = 8'd165;
  localparam logic [7:0]  ADDR_CLK1_PH  = 8'd166;
  localparam logic [7:0]  CLK_CTL_VAL   = 8'h4F;
  localparam logic [7:0]  RESET_VAL     = 8'h20;
  localparam logic [2:0]  WAIT_LONG     = 3'd5;

  localparam logic [2:0] CFG_XTAL   = 3'd0;
  localparam logic [2:0] CFG_CORR   = 3'd1;
  localparam logic [2:0] CFG_PLL_LO = 3'd2;
  localparam logic [2:0] CFG_PLL_HI = 3'd3;
  localparam logic [2:0] CFG_CENTRE = 3'd4;
endpackage
`default_nettype wire

// ----- src/quadrature_synth_register_planner.sv -----
// A request that needs a new divider runs three 32-step divisions (only the
// first at the largest divider) before the in-band steps: a 7-step multiply and
// 64- and 52-step divisions; then one beat per ready cycle to its last write.
// Throughput: one request at a time; 8, 27 or 30 beats.
// Reset: synchronous active-low rst_n restores the configuration defaults and
// clears divider and band state, so the first request does the full setup.
// ----------------------------------------------------------------------------
// quadrature_synth_register_planner
// Turns a requested frequency into the ordered synthesiser register writes.
// ----------------------------------------------------------------------------
`default_nettype none
module quadrature_synth_register_planner #(
  parameter int MAX_DIVIDER = 126
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [27:0] in_requested_hz,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_reg_addr,
  output logic [7:0]       out_reg_value,
  output logic [2:0]       out_wait_ms,
  output logic             out_last_write,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [29:0] cfg_data
);
  import qsrp_pkg::*;

  // Most of the datapath is one 64-bit dividend / 32-bit divisor restoring
  // divider and one shift-add multiplier; a small sequencer drives them
  // through the steps of a request one after the other.
  typedef enum logic [3:0] {
    S_IDLE, S_DIVSEL, S_BLO, S_BHI, S_MUL, S_PLLDIV, S_NUMMUL, S_NUMDIV,
    S_FIN, S_EMIT
  } state_t;

  state_t      state_r;
  logic [25:0] xtal_cfg_r;
  logic signed [16:0] corr_r;
  logic [29:0] pll_lo_r, pll_hi_r, centre_r;
  logic [6:0]  div_r, prev_div_r;
  logic [31:0] band_lo_r, band_hi_r;
  logic [27:0] freq_r;

  // Shared divider: quotient/remainder registers, one quotient bit per cycle.
  logic [63:0] dq_r;      // dividend shifting out, quotient shifting in
  logic [31:0] drem_r;
  logic [31:0] ddiv_r;
  logic [5:0]  dcnt_r;
  logic [32:0] dtrial;
  logic        dge;

  logic [35:0] pll_r;     // divider * frequency
  logic [8:0]  mult_r;
  logic [31:0] rem_r;
  logic [19:0] num_r;
  logic [31:0] p1_r, p2_r;
  logic [4:0]  idx_r;
  logic [4:0]  last_idx;
  logic        full_r, phase_r;
  logic [31:0] xtal;
  logic signed [27:0] xs;

  assign xs   = $signed({2'b00, xtal_cfg_r}) - 28'(corr_r);
  assign xtal = (xs < 28'sd1) ? 32'd1 : 32'(xs);

  assign dtrial = {drem_r, dq_r[63]} - {1'b0, ddiv_r};
  assign dge    = ~dtrial[32];

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign last_idx  = phase_r ? 5'd29 : (full_r ? 5'd26 : 5'd7);
  assign out_last_write = (idx_r == last_idx);

  // Emitted byte for the current beat.
  logic [31:0] bp1, bp2, bp3;
  logic [2:0]  sub;
  logic [31:0] msp1;
  assign msp1 = {18'd0, div_r, 7'd0} - 32'd512;
  always_comb begin
    sub = 3'(idx_r);
    bp1 = p1_r; bp2 = p2_r; bp3 = 32'(FRAC_DENOM);
    out_wait_ms = 3'd0;
    out_reg_addr = ADDR_PLL_A + {5'd0, sub};
    if (idx_r >= 5'd8 && idx_r < 5'd24) begin
      sub = 3'(idx_r - 5'd8);
      bp1 = msp1; bp2 = 32'd0; bp3 = 32'd1;
      out_reg_addr = ((idx_r < 5'd16) ? ADDR_MS0 : ADDR_MS1) + {5'd0, sub};
    end
    case (sub)
      3'd0: out_reg_value = bp3[15:8];
      3'd1: out_reg_value = bp3[7:0];
      3'd2: out_reg_value = {6'd0, bp1[17:16]};
      3'd3: out_reg_value = bp1[15:8];
      3'd4: out_reg_value = bp1[7:0];
      3'd5: out_reg_value = {bp3[19:16], bp2[19:16]};
      3'd6: out_reg_value = bp2[15:8];
      default: out_reg_value = bp2[7:0];
    endcase
    case (idx_r)
      5'd24: begin out_reg_addr = ADDR_PLL_RST;  out_reg_value = RESET_VAL; end
      5'd25: begin out_reg_addr = ADDR_CLK0_CTL; out_reg_value = CLK_CTL_VAL; end
      5'd26: begin out_reg_addr = ADDR_CLK1_CTL; out_reg_value = CLK_CTL_VAL; end
      5'd27: begin
        out_reg_addr = ADDR_CLK0_PH; out_reg_value = 8'd0; out_wait_ms = WAIT_LONG;
      end
      5'd28: begin
        out_reg_addr = ADDR_CLK1_PH; out_reg_value = {1'b0, div_r};
        out_wait_ms = WAIT_LONG;
      end
      5'd29: begin
        out_reg_addr = ADDR_PLL_RST; out_reg_value = RESET_VAL; out_wait_ms = WAIT_LONG;
      end
      default: ;
    endcase
  end

  logic [31:0] dsel;
  logic [6:0]  dchosen;
  assign dsel = dq_r[31:0];
  always_comb begin
    dchosen = 7'd0;
    if ({dsel[31:1], 1'b0} > 32'(MAX_DIVIDER)) dchosen = 7'(MAX_DIVIDER);
    else if (dsel < 32'd2) dchosen = 7'd2;
    else dchosen = {dsel[6:1], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      xtal_cfg_r <= 26'd25000000; corr_r <= '0;
      pll_lo_r <= 30'd600000000; pll_hi_r <= 30'd900000000;
      centre_r <= 30'd750000000;
      div_r <= '0; prev_div_r <= '0; band_lo_r <= '0; band_hi_r <= '0;
      idx_r <= '0; dcnt_r <= '0; full_r <= 1'b0; phase_r <= 1'b0;
    end else begin
      // The divider runs whenever its counter is non-zero.
      if (dcnt_r != 6'd0) begin
        dcnt_r <= dcnt_r - 6'd1;
        drem_r <= dge ? dtrial[31:0] : {drem_r[30:0], dq_r[63]};
        dq_r   <= {dq_r[62:0], dge};
      end
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index)
              CFG_XTAL:   xtal_cfg_r <= cfg_data[25:0];
              CFG_CORR:   corr_r <= cfg_data[16:0];
              CFG_PLL_LO: pll_lo_r <= cfg_data;
              CFG_PLL_HI: pll_hi_r <= cfg_data;
              CFG_CENTRE: centre_r <= cfg_data;
              default: ;
            endcase
          end
          if (in_valid) begin
            freq_r <= (in_requested_hz < MIN_FREQ) ? MIN_FREQ : in_requested_hz;
            state_r <= S_DIVSEL;
            dcnt_r <= 6'd0;
          end
        end
        S_DIVSEL: begin
          if ({4'd0, freq_r} > band_hi_r || {4'd0, freq_r} < band_lo_r) begin
            // centre / freq, 32 quotient bits
            dq_r <= {2'd0, centre_r, 32'd0}; drem_r <= '0;
            ddiv_r <= {4'd0, freq_r}; dcnt_r <= 6'd32;
            state_r <= S_BLO;
          end else begin
            state_r <= S_MUL;
          end
          pll_r <= '0; idx_r <= '0;
        end
        S_BLO: if (dcnt_r == 6'd0 && idx_r == 5'd0) begin
          div_r <= dchosen; idx_r <= 5'd1;
          if (dchosen == 7'(MAX_DIVIDER) && {dsel[31:1], 1'b0} > 32'(MAX_DIVIDER)) begin
            band_lo_r <= {4'd0, MIN_FREQ}; band_hi_r <= LOW_BAND_HIGH;
            idx_r <= 5'd0; state_r <= S_MUL;
          end else begin
            dq_r <= {2'd0, pll_lo_r, 32'd0}; drem_r <= '0;
            ddiv_r <= {25'd0, dchosen}; dcnt_r <= 6'd32;
          end
        end else if (dcnt_r == 6'd0) begin
          band_lo_r <= dsel;
          dq_r <= {2'd0, pll_hi_r, 32'd0}; drem_r <= '0; dcnt_r <= 6'd32;
          state_r <= S_BHI;
        end
        S_BHI: if (dcnt_r == 6'd0) begin
          band_hi_r <= dsel; idx_r <= '0; state_r <= S_MUL;
        end
        S_MUL: begin
          // shift-add: one divider bit per cycle
          pll_r <= pll_r + (div_r[idx_r[2:0]] ? ({8'd0, freq_r} << idx_r[2:0]) : 36'd0);
          if (idx_r == 5'd6) begin
            state_r <= S_PLLDIV;
          end
          idx_r <= idx_r + 5'd1;
        end
        S_PLLDIV: begin
          dq_r <= {28'd0, pll_r}; drem_r <= '0; ddiv_r <= xtal; dcnt_r <= 6'd63;
          state_r <= S_NUMMUL; idx_r <= '0;
        end
        S_NUMMUL: if (dcnt_r == 6'd0 && idx_r == 5'd0) begin
          // last quotient bit: dividend 64 bits, 63 steps plus this one
          mult_r <= ({dq_r[62:0], dge} > 64'd255) ? 9'd255 : 9'({dq_r[62:0], dge});
          rem_r <= dge ? dtrial[31:0] : {drem_r[30:0], dq_r[63]};
          idx_r <= 5'd1;
        end else if (dcnt_r == 6'd0) begin
          // rem * 1048575 = (rem << 20) - rem, then / xtal
          dq_r <= {({rem_r, 20'd0} - {20'd0, rem_r}), 12'd0};
          drem_r <= '0; dcnt_r <= 6'd52; state_r <= S_NUMDIV;
        end
        S_NUMDIV: if (dcnt_r == 6'd0) begin
          num_r <= dq_r[19:0]; state_r <= S_FIN;
        end
        S_FIN: begin
          // q = floor(128*num/1048575): num < 2^20 so q = num >> 13 with one fix-up
          logic [6:0] q;
          logic [27:0] n128;
          n128 = {1'b0, num_r, 7'd0};
          q = 7'(n128 >> 20);
          if ({1'b0, n128[26:0]} - 28'(q) * 28'(FRAC_DENOM) >= 28'(FRAC_DENOM)) q = q + 7'd1;
          p1_r <= {16'd0, mult_r, 7'd0} + 32'(q) - 32'd512;
          p2_r <= 32'(n128) - 32'(q) * 32'(FRAC_DENOM);
          full_r  <= (div_r != prev_div_r) || (prev_div_r == 7'd0);
          phase_r <= (div_r != prev_div_r);
          idx_r <= '0; state_r <= S_EMIT;
        end
        S_EMIT: if (out_ready) begin
          idx_r <= idx_r + 5'd1;
          if (out_last_write) begin
            state_r <= S_IDLE;
            if (full_r) prev_div_r <= div_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The last beat of a request is only ever shown at one of the three lengths.
  a_last_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_write) |-> (idx_r == 5'd7 || idx_r == 5'd26 || idx_r == 5'd29))
    else $error("bad request length");
  // No request is taken while writes are still being shown.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while emitting");
  // The divider chosen is even and at least two while writes are being shown.
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (div_r[0] == 1'b0 && div_r >= 7'd2)) else $error("bad divider");
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for the quadrature synthesiser register planner
// Sends frequency requests under random stalls on both channels and compares
// every register write beat with a cycle-free model of the planner.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qsrp_pkg::*;

  // One register write as the planner should emit it.
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] value;
    logic [2:0] wait_ms;
    logic       last;
  } reg_write_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [27:0] in_requested_hz;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_reg_addr;
  logic [7:0]  out_reg_value;
  logic [2:0]  out_wait_ms;
  logic        out_last_write;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [29:0] cfg_data;

  quadrature_synth_register_planner dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_requested_hz(in_requested_hz),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_reg_addr(out_reg_addr), .out_reg_value(out_reg_value),
    .out_wait_ms(out_wait_ms), .out_last_write(out_last_write),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model copy of the configuration registers.
  logic [25:0]        xtal_hz;
  logic signed [16:0] xtal_corr;
  logic [29:0]        pll_lo_hz;
  logic [29:0]        pll_hi_hz;
  logic [29:0]        pll_mid_hz;

  // Model copy of the planner state.
  logic [6:0]  cur_div;
  logic [31:0] band_lo;
  logic [31:0] band_hi;
  logic [6:0]  prev_div;

  reg_write_t pending_writes[$];
  int         error_count;
  int         reported;
  int         stall_left;
  int         hold_left;
  bit         quiet;        // when set, neither side idles
  logic [27:0] last_freq;

  localparam int DRAIN_CYCLES = 300;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous limit: the slowest legal run is well under five milliseconds.
  initial begin
    #30ms;
    $display("Verification failed");
    $finish;
  end

  task automatic model_reset();
    xtal_hz    = 26'd25000000;
    xtal_corr  = '0;
    pll_lo_hz  = 30'd600000000;
    pll_hi_hz  = 30'd900000000;
    pll_mid_hz = 30'd750000000;
    cur_div    = '0;
    band_lo    = '0;
    band_hi    = '0;
    prev_div   = '0;
  endtask

  // Appends the eight writes of one PLL or multisynth parameter block.
  function automatic void add_block(ref reg_write_t plan[$], input logic [7:0] base,
                                    input logic [31:0] p1, input logic [31:0] p2,
                                    input logic [31:0] p3);
    logic [7:0] vals[8];
    vals[0] = p3[15:8];
    vals[1] = p3[7:0];
    vals[2] = {6'b0, p1[17:16]};
    vals[3] = p1[15:8];
    vals[4] = p1[7:0];
    vals[5] = {p3[19:16], p2[19:16]};
    vals[6] = p2[15:8];
    vals[7] = p2[7:0];
    for (int i = 0; i < 8; i++) begin
      plan.push_back('{addr: base + 8'(i), value: vals[i], wait_ms: 3'd0, last: 1'b0});
    end
  endfunction

  // Works out the writes one request causes and queues them in order.
  task automatic plan_request(input logic [27:0] req);
    reg_write_t   plan[$];
    logic [31:0]  freq;
    logic [31:0]  d;
    longint       xs;
    logic [63:0]  xtal, pll, mult, rem, num, q;
    logic [31:0]  p1, p2, msp1;
    freq = {4'b0, req};
    if (freq < 32'(MIN_FREQ)) freq = 32'(MIN_FREQ);
    // A fresh divider is chosen whenever the frequency leaves the stored band.
    if (freq > band_hi || freq < band_lo) begin
      d = {2'b0, pll_mid_hz} / freq;
      if (d[0]) d = d - 1;
      if (d < 2) d = 2;
      if (d > 32'd126) begin
        d = 32'd126;
        band_lo = 32'(MIN_FREQ);
        band_hi = LOW_BAND_HIGH;
      end else begin
        band_lo = {2'b0, pll_lo_hz} / d;
        band_hi = {2'b0, pll_hi_hz} / d;
      end
      cur_div = d[6:0];
    end
    // A crystal that corrects to zero or below is taken as one hertz.
    xs = longint'({38'b0, xtal_hz}) - longint'(xtal_corr);
    if (xs < 1) xs = 1;
    xtal = 64'(xs);
    pll  = 64'(cur_div) * 64'(freq);
    mult = pll / xtal;
    rem  = pll % xtal;
    if (mult > 255) mult = 255;
    num  = (rem * 64'(FRAC_DENOM)) / xtal;
    q    = (64'd128 * num) / 64'(FRAC_DENOM);
    p1   = 32'(64'd128 * mult + q - 64'd512);
    p2   = 32'(64'd128 * num - 64'(FRAC_DENOM) * q);
    add_block(plan, ADDR_PLL_A, p1, p2, 32'(FRAC_DENOM));
    if (cur_div != prev_div || prev_div == 0) begin
      msp1 = 32'd128 * 32'(cur_div) - 32'd512;
      add_block(plan, ADDR_MS0, msp1, 32'd0, 32'd1);
      add_block(plan, ADDR_MS1, msp1, 32'd0, 32'd1);
      plan.push_back('{ADDR_PLL_RST, RESET_VAL, 3'd0, 1'b0});
      plan.push_back('{ADDR_CLK0_CTL, CLK_CTL_VAL, 3'd0, 1'b0});
      plan.push_back('{ADDR_CLK1_CTL, CLK_CTL_VAL, 3'd0, 1'b0});
      if (cur_div != prev_div) begin
        plan.push_back('{ADDR_CLK0_PH, 8'd0, WAIT_LONG, 1'b0});
        plan.push_back('{ADDR_CLK1_PH, {1'b0, cur_div}, WAIT_LONG, 1'b0});
        plan.push_back('{ADDR_PLL_RST, RESET_VAL, WAIT_LONG, 1'b0});
      end
      prev_div = cur_div;
    end
    plan[plan.size() - 1].last = 1'b1;
    foreach (plan[i]) pending_writes.push_back(plan[i]);
  endtask

  // Sender: one request beat after a random gap; valid is left high after
  // acceptance so that a back-to-back beat never sees it drop and rise.
  task automatic send_request(input logic [27:0] freq);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_requested_hz = freq;
    do @(posedge clk); while (!in_ready);
    plan_request(freq);
    last_freq = freq;
  endtask

  // Waits until every queued write has arrived and the block has gone idle.
  task automatic drain_writes();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block drained.
  task automatic write_register(input logic [2:0] idx, input logic [29:0] data);
    drain_writes();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_XTAL:   xtal_hz    = data[25:0];
      CFG_CORR:   xtal_corr  = data[16:0];
      CFG_PLL_LO: pll_lo_hz  = data;
      CFG_PLL_HI: pll_hi_hz  = data;
      CFG_CENTRE: pll_mid_hz = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver: ready drops for a random count after each beat, and for a
  // long stretch when a hold-off is asked for.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Checker: every accepted write beat is matched against the oldest plan.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      reg_write_t got, want;
      got = '{out_reg_addr, out_reg_value, out_wait_ms, out_last_write};
      stall_left = quiet ? 0 : $urandom_range(0, 17);
      if (pending_writes.size() == 0) begin
        error_count++;
        if (reported < 10) begin
          reported++;
          $display("unexpected write beat addr=%0d value=%0h", got.addr, got.value);
        end
      end else begin
        want = pending_writes.pop_front();
        if (got !== want) begin
          error_count++;
          if (reported < 10) begin
            reported++;
            $display("write mismatch: expected addr=%0d value=%02h wait=%0d last=%0b",
                     want.addr, want.value, want.wait_ms, want.last);
            $display("                actual   addr=%0d value=%02h wait=%0d last=%0b",
                     got.addr, got.value, got.wait_ms, got.last);
          end
        end
      end
    end
  end

  // Frequencies at the edges of the range and around the band boundaries.
  task automatic test_edge_frequencies();
    send_request(28'd0);
    send_request(28'd3499999);
    send_request(28'd3500000);
    send_request(28'd6950000);
    send_request(28'd6950001);
    send_request(28'd7000000);
    send_request(28'd7100000);
    send_request(28'd150000000);
    send_request(28'd149000000);
    send_request(28'd14000000);
    send_request(28'hFFFFFFF);
  endtask

  // Register extremes, including a crystal corrected below one hertz and a
  // tiny crystal that drives the multiplier into saturation.
  task automatic test_register_extremes();
    write_register(CFG_XTAL, 30'd10000000);
    write_register(CFG_CORR, 30'(-50000));
    send_request(28'd21000000);
    write_register(CFG_XTAL, 30'd40000000);
    write_register(CFG_CORR, 30'd50000);
    send_request(28'd50000000);
    write_register(CFG_CENTRE, 30'd0);
    write_register(CFG_PLL_LO, 30'd0);
    write_register(CFG_PLL_HI, 30'd1000000000);
    send_request(28'd9000000);
    write_register(CFG_CENTRE, 30'd1000000000);
    write_register(CFG_PLL_HI, 30'd0);
    send_request(28'd4000000);
    send_request(28'd120000000);
    write_register(CFG_XTAL, 30'd0);
    write_register(CFG_CORR, 30'd100);
    send_request(28'd5000000);
    write_register(CFG_XTAL, 30'd1000000);
    write_register(CFG_CORR, 30'd0);
    send_request(28'd60000000);
    write_register(CFG_XTAL, 30'h3FFFFFF);
    write_register(CFG_CORR, 30'h10000);
    send_request(28'd30000000);
  endtask

  // Picks a frequency: mostly small moves that stay in band, some jumps and
  // some requests below the clamp.
  function automatic logic [27:0] pick_frequency();
    int sel;
    int step;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 28'($urandom_range(0, 3600000));
    if (sel < 60) begin
      step = $urandom_range(0, 400000);
      if ($urandom_range(0, 1)) return 28'(last_freq + step);
      return (last_freq > step) ? 28'(last_freq - step) : 28'(step);
    end
    if (sel < 62) return 28'($urandom);
    return 28'($urandom_range(0, 150000000));
  endfunction

  task automatic randomise_registers();
    write_register(CFG_XTAL, 30'($urandom_range(10000000, 40000000)));
    write_register(CFG_CORR, 30'($urandom_range(0, 100000) - 50000));
    write_register(CFG_PLL_LO, 30'($urandom_range(0, 1000000000)));
    write_register(CFG_PLL_HI, 30'($urandom_range(0, 1000000000)));
    write_register(CFG_CENTRE, 30'($urandom_range(0, 1000000000)));
  endtask

  // Random traffic with register changes between phases.
  task automatic test_random_traffic();
    write_register(CFG_XTAL, 30'd25000000);
    write_register(CFG_CORR, 30'd0);
    write_register(CFG_PLL_LO, 30'd600000000);
    write_register(CFG_PLL_HI, 30'd900000000);
    write_register(CFG_CENTRE, 30'd750000000);
    for (int i = 0; i < 400; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i % 100 == 99) randomise_registers();
      send_request(pick_frequency());
    end
    quiet = 1'b0;
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // block backs up and holds its input off.
  task automatic test_output_hold();
    drain_writes();
    hold_left = 1500;
    for (int i = 0; i < 6; i++) send_request(pick_frequency());
  endtask

  // The sender waits for every write before each request.
  task automatic test_sender_pause();
    for (int i = 0; i < 4; i++) begin
      drain_writes();
      send_request(pick_frequency());
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_requested_hz = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_XTAL;
    cfg_data        = '0;
    error_count     = 0;
    reported        = 0;
    stall_left      = 0;
    hold_left       = 0;
    quiet           = 1'b0;
    last_freq       = 28'd7000000;
    model_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edge_frequencies();
    test_register_extremes();
    test_random_traffic();
    test_output_hold();
    test_sender_pause();
    drain_writes();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
